// ----- src/sbgph_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Spectrum bar group peak hold: shared package
// Field widths, divider constants, register codes, reset values, states and
// the command and status structs that join the controller to the datapath.
// ============================================================================
package sbgph_pkg;

   // Field widths fixed by the interface.
   localparam int MAG_W      = 16;
   localparam int LEVEL_W    = 16;
   localparam int BAR_NUM_W  = 8;
   localparam int GRP_W      = 7;
   localparam int SINK_W     = 8;
   localparam int SUM_W      = 22;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Largest group that is honored; larger settings are clamped to it.
   localparam int MAX_GROUP = 64;

   // Default depth of the held peak store.
   localparam int DEFAULT_MAX_BARS = 256;

   // The average is sum * ceil(2^RECIP_SHIFT / g) >> RECIP_SHIFT. With the
   // shift at SUM_W + GRP_W the result is the exact truncated quotient.
   localparam int RECIP_SHIFT = SUM_W + GRP_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int DIV_CNT_W   = $clog2(RECIP_W);
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_ONE = {1'b1, {RECIP_SHIFT{1'b0}}};

   // Register reset values.
   localparam logic [GRP_W-1:0]  GROUP_SIZE_RESET    = GRP_W'(1);
   localparam logic [SINK_W-1:0] SINK_RATE_RESET     = SINK_W'(1);
   localparam logic              PEAKS_ENABLED_RESET = 1'b0;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GROUP_SIZE    = 2'd0,
      CSR_SINK_RATE     = 2'd1,
      CSR_PEAKS_ENABLED = 2'd2
   } csr_index_type;

   // Controller states.
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_RECIP = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_PEAK  = 5'b10000
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;       // input transfer this cycle
      logic clear_step;   // zero one entry of the peak store
      logic recip_start;  // load the reciprocal divider
      logic recip_step;   // one bit of the reciprocal divider
      logic mul;          // multiply the group sum by the reciprocal
      logic peak;         // update the held peak and load the result register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic produce;      // the offered item completes a bar that is emitted
      logic clear_done;   // clearing pass is at its last entry
      logic recip_stale;  // group size changed, reciprocal must be rebuilt
      logic recip_done;   // reciprocal divider is at its last bit
   } dp_status_type;

endpackage

// ----- src/sbgph_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Spectrum bar group peak hold: controller
// One-hot state machine that sequences clearing, reciprocal rebuild and the
// two-step bar pipeline, and owns both handshakes.
// ============================================================================
module sbgph_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sbgph_pkg::dp_cmd_type    cmd,
   input  sbgph_pkg::dp_status_type status
);
   import sbgph_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = !status.recip_stale;
            cmd.accept = req_valid && !status.recip_stale;
            if (cmd.accept) begin
               if (status.produce) begin
                  state_in = ST_MUL;
               end
            end else if (status.recip_stale) begin
               cmd.recip_start = 1'b1;
               state_in        = ST_RECIP;
            end
         end
         ST_RECIP: begin
            cmd.recip_step = 1'b1;
            if (status.recip_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_PEAK;
         end
         ST_PEAK: begin
            // The next item may enter while this bar is retired.
            if (out_free) begin
               cmd.peak   = 1'b1;
               req_ready  = 1'b1;
               cmd.accept = req_valid;
               state_in   = (req_valid && status.produce) ? ST_MUL : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.peak) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/sbgph_datapath.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Spectrum bar group peak hold: datapath
// Configuration registers, group accumulator, reciprocal divider, averaging
// multiplier, held peak store and result register.
// ============================================================================
module sbgph_datapath #(
   parameter int MAX_BARS = sbgph_pkg::DEFAULT_MAX_BARS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [sbgph_pkg::MAG_W-1:0]    req_magnitude,
   input  logic                                  req_frame_last,
   input  logic                                  csr_write_enable,
   input  logic [sbgph_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sbgph_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  sbgph_pkg::dp_cmd_type                 cmd,
   output sbgph_pkg::dp_status_type              status,
   output logic [sbgph_pkg::BAR_NUM_W-1:0]       rsp_bar_number,
   output logic [sbgph_pkg::LEVEL_W-1:0]         rsp_bar_level,
   output logic [sbgph_pkg::LEVEL_W-1:0]         rsp_peak_level,
   output logic                                  rsp_frame_done
);
   import sbgph_pkg::*;

   localparam int BAR_AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
   localparam int BAR_CW = $clog2(MAX_BARS + 1);

   // Configuration.
   logic [GRP_W-1:0]  group_size_ff, group_size_in;
   logic [SINK_W-1:0] sink_rate_ff, sink_rate_in;
   logic              peaks_enabled_ff, peaks_enabled_in;
   logic              recip_stale_ff, recip_stale_in;
   logic [GRP_W-1:0]  g_eff;

   // Accumulator and bar counter.
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [GRP_W-1:0]  count_ff, count_in;
   logic [BAR_CW-1:0] next_bar_ff, next_bar_in;
   logic [MAG_W-1:0]  mag_bits;
   logic [MAG_W-1:0]  mag_abs;
   logic [SUM_W-1:0]  sum_next;
   logic [GRP_W-1:0]  count_next;
   logic              complete;
   logic              bar_open;

   // Bar in flight.
   logic [SUM_W-1:0]  stage_sum_ff, stage_sum_in;
   logic [BAR_AW-1:0] stage_bar_ff, stage_bar_in;
   logic              stage_last_ff, stage_last_in;

   // Reciprocal divider.
   logic [RECIP_W-1:0]   recip_ff, recip_in;
   logic [GRP_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [GRP_W:0]       div_shift;
   logic [GRP_W:0]       div_diff;
   logic                 div_fits;

   // Average. The level keeps the full sum width: a group that shrank
   // mid-way can average above 16 bits, and the peak compare needs all of it.
   logic [PROD_W-1:0]  product;
   logic [SUM_W-1:0]   level_ff, level_in;

   // Peak store.
   logic [LEVEL_W-1:0] peak_mem_ff [MAX_BARS];
   logic [LEVEL_W-1:0] rd_raw_ff;
   logic               fwd_ff, fwd_in;
   logic [LEVEL_W-1:0] fwd_data_ff, fwd_data_in;
   logic [BAR_AW-1:0]  clr_addr_ff, clr_addr_in;
   logic               mem_we;
   logic               mem_re;
   logic [BAR_AW-1:0]  mem_wa;
   logic [BAR_AW-1:0]  mem_ra;
   logic [LEVEL_W-1:0] mem_wd;
   logic [LEVEL_W-1:0] peak_cur;
   logic [LEVEL_W-1:0] peak_new;

   // Result register.
   logic [BAR_NUM_W-1:0] out_bar_ff, out_bar_in;
   logic [LEVEL_W-1:0]   out_level_ff, out_level_in;
   logic [LEVEL_W-1:0]   out_peak_ff, out_peak_in;
   logic                 out_last_ff, out_last_in;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   always_comb begin
      group_size_in    = group_size_ff;
      sink_rate_in     = sink_rate_ff;
      peaks_enabled_in = peaks_enabled_ff;
      recip_stale_in   = cmd.recip_start ? 1'b0 : recip_stale_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GROUP_SIZE: begin
               group_size_in  = csr_write_data[GRP_W-1:0];
               recip_stale_in = 1'b1;
            end
            CSR_SINK_RATE: begin
               sink_rate_in = csr_write_data[SINK_W-1:0];
            end
            CSR_PEAKS_ENABLED: begin
               peaks_enabled_in = csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // A group size of zero acts as one; sizes above the limit are clamped.
   always_comb begin
      if (group_size_ff == '0) begin
         g_eff = GRP_W'(1);
      end else if (group_size_ff > GRP_W'(MAX_GROUP)) begin
         g_eff = GRP_W'(MAX_GROUP);
      end else begin
         g_eff = group_size_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Group accumulation on each input transfer
   // ------------------------------------------------------------------------
   assign mag_bits   = req_magnitude;
   assign mag_abs    = mag_bits[MAG_W-1] ? (~mag_bits + MAG_W'(1)) : mag_bits;
   assign sum_next   = sum_ff + SUM_W'(mag_abs);
   assign count_next = count_ff + GRP_W'(1);
   assign complete   = (count_next >= g_eff);
   assign bar_open   = (next_bar_ff < BAR_CW'(MAX_BARS));

   always_comb begin
      sum_in        = sum_ff;
      count_in      = count_ff;
      next_bar_in   = next_bar_ff;
      stage_sum_in  = stage_sum_ff;
      stage_bar_in  = stage_bar_ff;
      stage_last_in = stage_last_ff;
      if (cmd.accept) begin
         if (complete) begin
            sum_in   = '0;
            count_in = '0;
            if (bar_open) begin
               next_bar_in   = next_bar_ff + BAR_CW'(1);
               stage_sum_in  = sum_next;
               stage_bar_in  = next_bar_ff[BAR_AW-1:0];
               stage_last_in = req_frame_last;
            end
         end else begin
            sum_in   = sum_next;
            count_in = count_next;
         end
         // The frame's last bin drops a partial group and restarts the bars.
         if (req_frame_last) begin
            sum_in      = '0;
            count_in    = '0;
            next_bar_in = '0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Reciprocal divider: ceil(2^RECIP_SHIFT / g), one quotient bit a cycle
   // ------------------------------------------------------------------------
   assign div_shift = {rem_ff, recip_ff[RECIP_W-1]};
   assign div_fits  = (div_shift >= {1'b0, g_eff});
   assign div_diff  = div_shift - {1'b0, g_eff};

   always_comb begin
      recip_in   = recip_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.recip_start) begin
         recip_in   = RECIP_ONE + RECIP_W'(g_eff) - RECIP_W'(1);
         rem_in     = '0;
         div_cnt_in = '0;
      end else if (cmd.recip_step) begin
         recip_in   = {recip_ff[RECIP_W-2:0], div_fits};
         rem_in     = div_fits ? div_diff[GRP_W-1:0] : div_shift[GRP_W-1:0];
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // ------------------------------------------------------------------------
   // Average of the completed group
   // ------------------------------------------------------------------------
   assign product  = stage_sum_ff * recip_ff;
   assign level_in = cmd.mul ? product[RECIP_SHIFT +: SUM_W] : level_ff;

   // ------------------------------------------------------------------------
   // Held peak update and peak store
   // ------------------------------------------------------------------------
   assign peak_cur = fwd_ff ? fwd_data_ff : rd_raw_ff;

   always_comb begin
      peak_new = peak_cur;
      if (peaks_enabled_ff) begin
         if (SUM_W'(peak_cur) > level_ff) begin
            if (peak_cur > LEVEL_W'(sink_rate_ff)) begin
               peak_new = peak_cur - LEVEL_W'(sink_rate_ff);
            end else begin
               peak_new = '0;
            end
         end else begin
            peak_new = level_ff[LEVEL_W-1:0];
         end
      end
   end

   assign mem_we      = cmd.clear_step || cmd.peak;
   assign mem_wa      = cmd.clear_step ? clr_addr_ff : stage_bar_ff;
   assign mem_wd      = cmd.clear_step ? '0 : peak_new;
   assign mem_re      = cmd.accept && status.produce;
   assign mem_ra      = next_bar_ff[BAR_AW-1:0];
   assign clr_addr_in = cmd.clear_step ? (clr_addr_ff + BAR_AW'(1)) : clr_addr_ff;

   // A read of the entry written in the same cycle takes the new value.
   assign fwd_in      = mem_re ? (mem_we && (mem_ra == mem_wa)) : fwd_ff;
   assign fwd_data_in = mem_re ? mem_wd : fwd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         peak_mem_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_raw_ff <= peak_mem_ff[mem_ra];
      end
   end

   // ------------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------------
   assign out_bar_in   = cmd.peak ? BAR_NUM_W'(stage_bar_ff) : out_bar_ff;
   assign out_level_in = cmd.peak ? level_ff[LEVEL_W-1:0] : out_level_ff;
   assign out_peak_in  = cmd.peak ? peak_new : out_peak_ff;
   assign out_last_in  = cmd.peak ? stage_last_ff : out_last_ff;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff    <= GROUP_SIZE_RESET;
         sink_rate_ff     <= SINK_RATE_RESET;
         peaks_enabled_ff <= PEAKS_ENABLED_RESET;
         recip_stale_ff   <= 1'b0;
         sum_ff           <= '0;
         count_ff         <= '0;
         next_bar_ff      <= '0;
         recip_ff         <= RECIP_ONE;
         rem_ff           <= '0;
         div_cnt_ff       <= '0;
         fwd_ff           <= 1'b0;
         clr_addr_ff      <= '0;
      end else begin
         group_size_ff    <= group_size_in;
         sink_rate_ff     <= sink_rate_in;
         peaks_enabled_ff <= peaks_enabled_in;
         recip_stale_ff   <= recip_stale_in;
         sum_ff           <= sum_in;
         count_ff         <= count_in;
         next_bar_ff      <= next_bar_in;
         recip_ff         <= recip_in;
         rem_ff           <= rem_in;
         div_cnt_ff       <= div_cnt_in;
         fwd_ff           <= fwd_in;
         clr_addr_ff      <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_sum_ff  <= stage_sum_in;
      stage_bar_ff  <= stage_bar_in;
      stage_last_ff <= stage_last_in;
      level_ff      <= level_in;
      fwd_data_ff   <= fwd_data_in;
      out_bar_ff    <= out_bar_in;
      out_level_ff  <= out_level_in;
      out_peak_ff   <= out_peak_in;
      out_last_ff   <= out_last_in;
   end

   assign status.produce     = complete && bar_open;
   assign status.clear_done  = (clr_addr_ff == BAR_AW'(MAX_BARS - 1));
   assign status.recip_stale = recip_stale_ff;
   assign status.recip_done  = (div_cnt_ff == DIV_CNT_W'(RECIP_W - 1));

   assign rsp_bar_number = out_bar_ff;
   assign rsp_bar_level  = out_level_ff;
   assign rsp_peak_level = out_peak_ff;
   assign rsp_frame_done = out_last_ff;

endmodule

// ----- src/spectrum_bar_group_peak_hold_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Spectrum bar group peak hold: top level
// Averages groups of spectrum bin magnitudes into bars and keeps a decaying
// held peak per bar.
// ============================================================================
//
//  Channel  Direction  Handshake             Transfer carries
//  -------  ---------  --------------------  ---------------------------------
//  req      in         req_valid/req_ready   magnitude, frame_last
//  rsp      out        rsp_valid/rsp_ready   bar_number, bar_level,
//                                            peak_level, frame_done
//  csr      in         csr_write_enable      csr_index, csr_write_data
//
//  A bin that does not complete a bar only updates the group accumulator. A
//  bin that completes a bar is taken, then averaged in the multiplier; the
//  held peak update overlaps the next transfer.
//  After reset the MAX_BARS entries of the peak store are zeroed one entry a
//  cycle, with req_ready low. Writing group_size rebuilds the reciprocal of
//  the group size bit by bit, also with req_ready low.
//  A result waiting in the output register stalls the next bar and the input.
//
module spectrum_bar_group_peak_hold_top #(
   parameter int MAX_BARS = sbgph_pkg::DEFAULT_MAX_BARS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [sbgph_pkg::MAG_W-1:0]    req_magnitude,
   input  logic                                  req_frame_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sbgph_pkg::BAR_NUM_W-1:0]       rsp_bar_number,
   output logic [sbgph_pkg::LEVEL_W-1:0]         rsp_bar_level,
   output logic [sbgph_pkg::LEVEL_W-1:0]         rsp_peak_level,
   output logic                                  rsp_frame_done,
   input  logic                                  csr_write_enable,
   input  logic [sbgph_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sbgph_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import sbgph_pkg::*;

   // Commands and status between the controller and the datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller owns both handshakes and decides, cycle by cycle, which
   // datapath step runs: clearing, reciprocal rebuild, accumulation,
   // averaging or the peak update.
   sbgph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the configuration, the group accumulator, the
   // divider, the multiplier, the peak store and the result register.
   sbgph_datapath #(
      .MAX_BARS (MAX_BARS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_magnitude    (req_magnitude),
      .req_frame_last   (req_frame_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_bar_number   (rsp_bar_number),
      .rsp_bar_level    (rsp_bar_level),
      .rsp_peak_level   (rsp_peak_level),
      .rsp_frame_done   (rsp_frame_done)
   );

   // The sequencing steps never overlap.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.recip_start, cmd.recip_step, cmd.mul, cmd.peak}))
      else $error("more than one datapath step issued in one cycle");

   // A transfer that completes a bar is averaged in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.produce) |=> cmd.mul)
      else $error("completed bar was not averaged in the following cycle");

   // Every peak update leaves a result in the output register.
   assert property (@(posedge clock) disable iff (reset)
      cmd.peak |=> rsp_valid)
      else $error("peak update did not present a result");

   // No input transfer is possible while the reciprocal is being rebuilt.
   assert property (@(posedge clock) disable iff (reset)
      cmd.recip_start |-> !req_ready)
      else $error("input taken while the reciprocal rebuild starts");

endmodule

// ----- dv/tb_spectrum_bar_group_peak_hold_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Spectrum bar group peak hold: testbench
// Streams spectrum bins into the block and checks every bar that comes out
// against a local model of the grouping, averaging and peak hold logic.
// The run covers a short directed sequence, then frames of random bins under
// three sender and receiver idling patterns.
// ============================================================================
module tb_spectrum_bar_group_peak_hold_top;
   import sbgph_pkg::*;

   localparam int BAR_LIMIT = DEFAULT_MAX_BARS;
   // Quiet cycles before a register write. The block may still be chewing on
   // bins that produce no bar, or rebuilding the group size reciprocal.
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_CYCLES = 40;
   // Long receiver hold-off that backs the block up into its input.
   localparam int RSP_HOLD_CYCLES = 300;
   // Cycles without any transfer before the run is declared hung. This has to
   // cover the peak store clear after reset, the hold-off and the settle gaps.
   localparam int WATCHDOG_LIMIT = 5000;

   // One spectrum bin as offered on the request channel.
   typedef struct {
      logic signed [MAG_W-1:0] magnitude;
      logic                    frame_last;
   } bin_item_type;

   // One bar as it should appear on the response channel.
   typedef struct {
      logic [BAR_NUM_W-1:0] bar_number;
      logic [LEVEL_W-1:0]   bar_level;
      logic [LEVEL_W-1:0]   peak_level;
      logic                 frame_done;
   } bar_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [MAG_W-1:0] req_magnitude = '0;
   logic                 req_frame_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BAR_NUM_W-1:0] rsp_bar_number;
   logic [LEVEL_W-1:0]   rsp_bar_level;
   logic [LEVEL_W-1:0]   rsp_peak_level;
   logic                 rsp_frame_done;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GROUP_SIZE;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // Bins waiting to be offered, and bars the model says are still owed.
   bin_item_type   pending_bins[$];
   bar_result_type expected_bars[$];

   // Model copy of the configuration registers.
   logic [GRP_W-1:0]  cfg_group_size = GROUP_SIZE_RESET;
   logic [SINK_W-1:0] cfg_sink_rate = SINK_RATE_RESET;
   logic              cfg_peaks_enabled = PEAKS_ENABLED_RESET;

   // Model copy of the block state.
   logic [SUM_W-1:0]   group_sum = '0;
   int                 bins_in_group = 0;
   int                 bar_index = 0;
   logic [LEVEL_W-1:0] held_level [BAR_LIMIT];

   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   bit bin_taken = 1'b0;
   bit hold_rsp_now = 1'b0;
   int rsp_hold_left = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int bins_sent = 0;
   int bars_checked = 0;

   spectrum_bar_group_peak_hold_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_magnitude    (req_magnitude),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bar_number   (rsp_bar_number),
      .rsp_bar_level    (rsp_bar_level),
      .rsp_peak_level   (rsp_peak_level),
      .rsp_frame_done   (rsp_frame_done),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // A group size of zero behaves as one, and anything above the largest
   // supported group is clamped to it.
   function automatic int unsigned effective_group();
      if (cfg_group_size == 0) begin
         return 1;
      end
      if (cfg_group_size > MAX_GROUP) begin
         return MAX_GROUP;
      end
      return 32'(cfg_group_size);
   endfunction

   // Advances the model by one accepted bin and queues the bar it completes.
   // The level is compared against the peak at full width and only cut to
   // 16 bits on the way out, so a group that shrank mid-way can wrap.
   function automatic void predict_bar(bin_item_type bin);
      int             mag;
      int unsigned    g;
      int unsigned    level;
      int unsigned    peak;
      bar_result_type bar;
      g = effective_group();
      mag = 32'(bin.magnitude);
      if (mag < 0) begin
         mag = -mag;
      end
      group_sum = group_sum + SUM_W'(mag);
      bins_in_group++;
      if (bins_in_group >= g) begin
         // Bars beyond the store depth are swallowed without touching a peak.
         if (bar_index < BAR_LIMIT) begin
            level = group_sum / g;
            peak = 32'(held_level[bar_index]);
            if (cfg_peaks_enabled) begin
               if (peak > level) begin
                  peak = (peak > cfg_sink_rate) ? peak - cfg_sink_rate : 0;
               end else begin
                  peak = level;
               end
               held_level[bar_index] = peak[LEVEL_W-1:0];
            end
            bar.bar_number = bar_index[BAR_NUM_W-1:0];
            bar.bar_level = level[LEVEL_W-1:0];
            bar.peak_level = peak[LEVEL_W-1:0];
            bar.frame_done = bin.frame_last;
            expected_bars.push_back(bar);
            bar_index++;
         end
         group_sum = '0;
         bins_in_group = 0;
      end
      // The last bin of a frame always throws away a partial group and
      // restarts the bar count.
      if (bin.frame_last) begin
         group_sum = '0;
         bins_in_group = 0;
         bar_index = 0;
      end
   endfunction

   function automatic void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%t: %s", $realtime, msg);
      end
   endfunction

   function automatic void push_bin(int mag, bit last);
      bin_item_type bin;
      bin.magnitude = MAG_W'(mag);
      bin.frame_last = last;
      pending_bins.push_back(bin);
   endfunction

   // Bins lean toward the corners: full scale either way, zero, tiny values,
   // and otherwise any 16-bit pattern.
   function automatic int random_magnitude();
      case ($urandom_range(7))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return $urandom_range(1) ? $urandom_range(300) : -$urandom_range(300);
         default: return $signed(16'($urandom_range(16'hFFFF)));
      endcase
   endfunction

   // Queues one frame and returns how many bins it holds. Most frames are a
   // whole number of groups so that the same few bars come back frame after
   // frame and the held peaks get to decay; some carry a trailing partial
   // group, and a few are plain noise with a random end flag.
   function automatic int queue_frame(int unsigned g);
      int kind;
      int len;
      kind = $urandom_range(9);
      if (kind == 0) begin
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            push_bin(random_magnitude(), (i == len - 1) && ($urandom_range(3) == 0));
         end
         return len;
      end
      len = g * $urandom_range(1, (g >= 16) ? 2 : 6);
      if (kind == 1 && g > 1) begin
         len += $urandom_range(1, g - 1);
      end
      for (int i = 0; i < len; i++) begin
         push_bin(random_magnitude(), i == len - 1);
      end
      return len;
   endfunction

   // Waits out the settle gap, then writes one register for a single cycle.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_index <= idx;
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_GROUP_SIZE:    cfg_group_size = value[GRP_W-1:0];
         CSR_SINK_RATE:     cfg_sink_rate = value[SINK_W-1:0];
         CSR_PEAKS_ENABLED: cfg_peaks_enabled = value[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_bins.size() != 0 || expected_bars.size() != 0);
   endtask

   // One configuration, then random frames in two halves. Between the halves
   // the sender runs dry until every owed bar has come back.
   task automatic run_phase(int group_code, int sink, bit enable, int items,
                            bit hold_rsp);
      int queued;
      write_reg(CSR_GROUP_SIZE, CSR_DATA_W'(group_code));
      write_reg(CSR_SINK_RATE, CSR_DATA_W'(sink));
      write_reg(CSR_PEAKS_ENABLED, CSR_DATA_W'(enable));
      for (int half = 0; half < 2; half++) begin
         queued = 0;
         while (queued < items / 2) begin
            queued += queue_frame(effective_group());
         end
         if (hold_rsp && half == 0) begin
            @(posedge clock);
            hold_rsp_now = 1'b1;
         end
         wait_drained();
      end
   endtask

   // Sender: a new bin is offered only once the previous one has been taken,
   // and each fresh offer may be skipped to leave a gap.
   always @(negedge clock) begin
      if (!reset && (!req_valid || bin_taken)) begin
         bin_taken = 1'b0;
         if (pending_bins.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
            req_valid <= 1'b1;
            req_magnitude <= pending_bins[0].magnitude;
            req_frame_last <= pending_bins[0].frame_last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request that it counts
   // out itself.
   always @(negedge clock) begin
      if (hold_rsp_now) begin
         hold_rsp_now = 1'b0;
         rsp_hold_left = RSP_HOLD_CYCLES;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // Monitor: every request transfer feeds the model, every response transfer
   // is checked against the oldest owed bar, and a watchdog watches for a
   // block that has stopped moving.
   always @(posedge clock) begin
      bin_item_type   bin;
      bar_result_type bar;
      if (!reset) begin
         if (req_valid && req_ready) begin
            bin = pending_bins.pop_front();
            bin_taken = 1'b1;
            bins_sent++;
            predict_bar(bin);
         end
         if (rsp_valid && rsp_ready) begin
            bars_checked++;
            if (expected_bars.size() == 0) begin
               flag_mismatch($sformatf(
                  "unexpected bar: bar %0d level %0d peak %0d done %0b",
                  rsp_bar_number, rsp_bar_level, rsp_peak_level, rsp_frame_done));
            end else begin
               bar = expected_bars.pop_front();
               if (rsp_bar_number !== bar.bar_number || rsp_bar_level !== bar.bar_level ||
                   rsp_peak_level !== bar.peak_level || rsp_frame_done !== bar.frame_done)
               begin
                  flag_mismatch($sformatf({"bar mismatch: expected bar %0d level %0d ",
                     "peak %0d done %0b, got bar %0d level %0d peak %0d done %0b"},
                     bar.bar_number, bar.bar_level, bar.peak_level, bar.frame_done,
                     rsp_bar_number, rsp_bar_level, rsp_peak_level, rsp_frame_done));
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%t: watchdog: no transfer for %0d cycles, %0d bars owed",
                     $realtime, idle_cycles, expected_bars.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      foreach (held_level[i]) begin
         held_level[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The peak store is being cleared; the block is ready once that is over.
      do begin
         @(negedge clock);
      end while (!req_ready);

      // Directed part, with the sender and receiver never idling.
      // Reset settings: single-bin groups, peak hold off, so every peak reads
      // zero. Full scale both ways, zero and minus one.
      push_bin(32767, 1'b0);
      push_bin(-32768, 1'b0);
      push_bin(0, 1'b0);
      push_bin(-1, 1'b0);
      push_bin(1, 1'b1);
      wait_drained();

      // Pairs with the fastest sink: the peaks jump to the first levels, the
      // frame ends on a lone bin that is dropped, and the next frame of
      // quiet bars pulls both peaks down by the full sink rate.
      write_reg(CSR_PEAKS_ENABLED, CSR_DATA_W'(1));
      write_reg(CSR_SINK_RATE, CSR_DATA_W'(255));
      write_reg(CSR_GROUP_SIZE, CSR_DATA_W'(2));
      push_bin(32767, 1'b0);
      push_bin(-32768, 1'b0);
      push_bin(-32768, 1'b0);
      push_bin(-32768, 1'b0);
      push_bin(100, 1'b1);
      push_bin(0, 1'b0);
      push_bin(0, 1'b0);
      push_bin(5, 1'b0);
      push_bin(5, 1'b1);
      wait_drained();

      // The group shrinks while one is half full: three full-scale bins sit
      // in a group of four, the size drops to two, and the next bin closes
      // the group with a sum too large for the 16-bit level.
      write_reg(CSR_GROUP_SIZE, CSR_DATA_W'(4));
      push_bin(-32768, 1'b0);
      push_bin(-32768, 1'b0);
      push_bin(-32768, 1'b0);
      wait_drained();
      write_reg(CSR_GROUP_SIZE, CSR_DATA_W'(2));
      push_bin(-32768, 1'b1);
      wait_drained();

      // A group size of zero acts as one, then a sink rate of zero holds a
      // peak that sits above its bar.
      write_reg(CSR_GROUP_SIZE, CSR_DATA_W'(0));
      push_bin(7, 1'b0);
      push_bin(-7, 1'b1);
      wait_drained();
      write_reg(CSR_SINK_RATE, CSR_DATA_W'(0));
      push_bin(1, 1'b0);
      push_bin(2, 1'b1);
      wait_drained();

      // Random frames, sender idling more lightly than the receiver.
      snd_idle_pct = 27;
      rcv_idle_pct = 65;
      run_phase(3, 7, 1'b1, 120, 1'b0);
      run_phase(1, 0, 1'b1, 80, 1'b0);
      // One frame longer than the bar store: bars past the limit vanish.
      for (int i = 0; i < BAR_LIMIT + 14; i++) begin
         push_bin(random_magnitude(), i == BAR_LIMIT + 13);
      end
      wait_drained();
      // All ones in the data byte: the top bit is ignored and the rest
      // clamps to the largest group.
      run_phase(255, 200, 1'b1, 110, 1'b0);

      // Now the receiver idles more lightly than the sender. The second phase
      // freezes the held peaks that the earlier phases built up.
      snd_idle_pct = 65;
      rcv_idle_pct = 27;
      run_phase(5, 255, 1'b1, 100, 1'b0);
      run_phase(0, 1, 1'b0, 70, 1'b0);

      // No idling at all; the first phase holds the receiver off long enough
      // to back the block up into its input.
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      run_phase(1, 3, 1'b1, 70, 1'b1);
      run_phase(MAX_GROUP, 128, 1'b1, 110, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_bars.size() != 0) begin
         flag_mismatch($sformatf("%0d bars never arrived", expected_bars.size()));
      end

      $display("Sent %0d bins and checked %0d bars, %0d mismatches.",
               bins_sent, bars_checked, mismatches);
      $display({"Group sizes 0 to 127, sink rates 0 to 255, peak hold on and off, ",
                "bars past the store depth and a long output stall were covered."});
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/sbgph_pkg.sv
src/sbgph_ctrl.sv
src/sbgph_datapath.sv
src/spectrum_bar_group_peak_hold_top.sv
dv/tb_spectrum_bar_group_peak_hold_top.sv
